// ===== hdl/scl_pkg.sv =====
`timescale 1ns / 1ps
package scl_pkg;

  localparam int unsigned VTX_W          = 7;
  localparam int unsigned DEF_VERTICES   = 64;
  localparam int unsigned DEF_EDGES      = 1024;
  localparam logic [VTX_W-1:0] VC_RESET  = 7'd64;

  typedef struct packed {
    logic load;
    logic clear;
  } edge_ctl_t;

  typedef enum logic [8:0] {
    ST_LOAD      = 9'b000000001,
    ST_ROOT1     = 9'b000000010,
    ST_SCAN_RD   = 9'b000000100,
    ST_SCAN_CHK  = 9'b000001000,
    ST_POP       = 9'b000010000,
    ST_POP_WAIT  = 9'b000100000,
    ST_ROOT2_RD  = 9'b001000000,
    ST_ROOT2_CHK = 9'b010000000,
    ST_FLUSH     = 9'b100000000
  } state_e;

endpackage

// ===== hdl/scl_if.sv =====
`timescale 1ns / 1ps
interface scl_edge_if import scl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] edge_src;
  logic [VTX_W-1:0] edge_dst;
  logic             edge_last;
  modport source (output valid, edge_src, edge_dst, edge_last, input ready);
  modport sink   (input valid, edge_src, edge_dst, edge_last, output ready);
endinterface

interface scl_leader_if import scl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] leader_vertex;
  logic             leader_last;
  logic             edges_dropped;
  modport source (output valid, leader_vertex, leader_last, edges_dropped, input ready);
  modport sink   (input valid, leader_vertex, leader_last, edges_dropped, output ready);
endinterface

interface scl_cfg_if import scl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/strongly_connected_leaders.sv =====
`timescale 1ns / 1ps
// Strongly connected component leaders of a directed graph (Kosaraju).
// edge_i takes one edge word per cycle while the block is loading; edges
// with a vertex of 0 or above the vertex count in use (vertex_count held
// to 1..MAX_VERTICES), or beyond MAX_EDGES, are dropped and flagged. The
// word with edge_last set starts the run and edge_i.ready stays low until
// the last leader sits in the output register. Pass one walks forward
// edges from the highest vertex down; pass two walks reversed edges in
// decreasing finishing order. Each edge scan step is an edge memory read,
// then a check; each vertex adds a root try, an end-of-list read, a pop
// and a stack read per pass.
// leader_o gives one word per component in discovery order; leader_last
// marks the final one and edges_dropped repeats the flag on each. A leader
// is held one step so that the last one can be marked. When leader_o
// stalls, the walk waits at the next leader found.
// cfg_i writes vertex_count (reset 64); it is always ready and is to be
// written only while the block is idle. Reset empties the edge store.
module strongly_connected_leaders import scl_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_VERTICES,
  parameter int unsigned MAX_EDGES    = DEF_EDGES
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  scl_edge_if.sink     edge_i,
  scl_leader_if.source leader_o,
  scl_cfg_if.sink      cfg_i
);

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned VW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = $clog2(MAX_EDGES);

  state_e state_q, state_d;

  logic [VTX_W-1:0] vc_q;
  logic [VTX_W-1:0] n;
  logic             pass2_q;
  logic [VTX_W-1:0] root_q;
  logic [VTX_W-1:0] here_q;
  logic [EW-1:0]    cur_q;
  logic [VW-1:0]    depth_q;
  logic [VW-1:0]    fin_tot_q;
  logic [VW-1:0]    fi_q;
  logic [MAX_VERTICES-1:0] visited_q;

  logic [VTX_W-1:0] stk_vtx [MAX_VERTICES];
  logic [EW-1:0]    stk_cur [MAX_VERTICES];
  logic [VTX_W-1:0] stk_vtx_rd;
  logic [EW-1:0]    stk_cur_rd;
  logic [AW-1:0]    fin_mem [MAX_VERTICES];
  logic [AW-1:0]    fin_rd;

  logic [VTX_W-1:0] pend_q;
  logic             pend_vld_q;
  logic             out_vld_q, out_last_q, out_drop_q;
  logic [VTX_W-1:0] out_vtx_q;
  logic             out_free;
  logic             out_load;

  edge_ctl_t        ectl;
  logic [AW-1:0]    e_src, e_dst;
  logic [EW-1:0]    e_total;
  logic             e_dropped;

  logic [AW-1:0]    from_raw, to_raw;
  logic [VTX_W-1:0] from_v, to_v, root2_v;
  logic             take;
  logic [VW-1:0]    depth_m1;

  // effective vertex count
  always_comb begin
    if (vc_q == '0)                          n = 7'd1;
    else if (vc_q > VTX_W'(MAX_VERTICES))    n = VTX_W'(MAX_VERTICES);
    else                                     n = vc_q;
  end

  assign edge_i.ready = state_q == ST_LOAD;
  assign cfg_i.ready  = 1'b1;
  assign out_free     = !out_vld_q || leader_o.ready;
  assign out_load     = ((state_q == ST_ROOT2_CHK) && !visited_q[fin_rd] && pend_vld_q
                         && out_free) || ((state_q == ST_FLUSH) && out_free);

  assign ectl.load  = edge_i.valid && edge_i.ready;
  assign ectl.clear = (state_q == ST_FLUSH) && out_free;

  scl_edge_store #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_store (
    .clk_i, .rst_ni,
    .ctl_i     (ectl),
    .src_i     (edge_i.edge_src),
    .dst_i     (edge_i.edge_dst),
    .n_i       (n),
    .rd_addr_i (cur_q[EAW-1:0]),
    .rd_src_o  (e_src),
    .rd_dst_o  (e_dst),
    .total_o   (e_total),
    .dropped_o (e_dropped)
  );

  assign from_raw = pass2_q ? e_dst : e_src;
  assign to_raw   = pass2_q ? e_src : e_dst;
  assign from_v   = VTX_W'(from_raw) + 7'd1;
  assign to_v     = VTX_W'(to_raw) + 7'd1;
  assign root2_v  = VTX_W'(fin_rd) + 7'd1;
  assign take     = (from_v == here_q) && (to_v <= n) && !visited_q[to_raw];
  assign depth_m1 = depth_q - VW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:      if (ectl.load && edge_i.edge_last) state_d = ST_ROOT1;
      ST_ROOT1: begin
        if (root_q == '0)  state_d = ST_ROOT2_RD;
        else if (!visited_q[AW'(root_q - 7'd1)]) state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD:   state_d = (cur_q >= e_total) ? ST_POP : ST_SCAN_CHK;
      ST_SCAN_CHK:  state_d = ST_SCAN_RD;
      ST_POP: begin
        if (depth_m1 != '0) state_d = ST_POP_WAIT;
        else                state_d = pass2_q ? ST_ROOT2_RD : ST_ROOT1;
      end
      ST_POP_WAIT:  state_d = ST_SCAN_RD;
      ST_ROOT2_RD:  state_d = (fi_q == '0) ? ST_FLUSH : ST_ROOT2_CHK;
      ST_ROOT2_CHK: begin
        if (visited_q[fin_rd]) state_d = ST_ROOT2_RD;
        else if (!pend_vld_q || out_free) state_d = ST_SCAN_RD;
      end
      ST_FLUSH:     if (out_free) state_d = ST_LOAD;
      default:      state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      vc_q       <= VC_RESET;
      pass2_q    <= 1'b0;
      root_q     <= '0;
      depth_q    <= '0;
      fin_tot_q  <= '0;
      fi_q       <= '0;
      visited_q  <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) vc_q <= cfg_i.data;
      if (out_load)             out_vld_q <= 1'b1;
      else if (leader_o.ready)  out_vld_q <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (ectl.load && edge_i.edge_last) begin
            visited_q <= '0;
            fin_tot_q <= '0;
            root_q    <= n;
            pass2_q   <= 1'b0;
          end
        end
        ST_ROOT1: begin
          if (root_q == '0) begin
            visited_q <= '0;
            fi_q      <= fin_tot_q;
            pass2_q   <= 1'b1;
          end else begin
            if (!visited_q[AW'(root_q - 7'd1)]) begin
              visited_q[AW'(root_q - 7'd1)] <= 1'b1;
              depth_q <= VW'(1);
            end
            root_q <= root_q - 7'd1;
          end
        end
        ST_SCAN_CHK: begin
          if (take) begin
            visited_q[to_raw] <= 1'b1;
            depth_q <= depth_q + VW'(1);
          end
        end
        ST_POP: begin
          depth_q <= depth_m1;
          if (!pass2_q) fin_tot_q <= fin_tot_q + VW'(1);
        end
        ST_ROOT2_RD: begin
          if (fi_q != '0) fi_q <= fi_q - VW'(1);
        end
        ST_ROOT2_CHK: begin
          if (!visited_q[fin_rd] && (!pend_vld_q || out_free)) begin
            // hand the held leader on, hold the new one
            pend_vld_q       <= 1'b1;
            visited_q[fin_rd] <= 1'b1;
            depth_q          <= VW'(1);
          end
        end
        ST_FLUSH: begin
          if (out_free) pend_vld_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers and memories
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_ROOT1: begin
        here_q <= root_q;
        cur_q  <= '0;
      end
      ST_SCAN_CHK: begin
        if (take) begin
          stk_vtx[AW'(depth_m1)] <= here_q;
          stk_cur[AW'(depth_m1)] <= cur_q + EW'(1);
          here_q <= to_v;
          cur_q  <= '0;
        end else begin
          cur_q <= cur_q + EW'(1);
        end
      end
      ST_POP: begin
        if (!pass2_q) fin_mem[AW'(fin_tot_q)] <= AW'(here_q - 7'd1);
        stk_vtx_rd <= stk_vtx[AW'(depth_m1 - VW'(1))];
        stk_cur_rd <= stk_cur[AW'(depth_m1 - VW'(1))];
      end
      ST_POP_WAIT: begin
        here_q <= stk_vtx_rd;
        cur_q  <= stk_cur_rd;
      end
      ST_ROOT2_RD: begin
        fin_rd <= fin_mem[AW'(fi_q - VW'(1))];
      end
      ST_ROOT2_CHK: begin
        if (!visited_q[fin_rd] && (!pend_vld_q || out_free)) begin
          if (pend_vld_q) begin
            out_vtx_q  <= pend_q;
            out_last_q <= 1'b0;
            out_drop_q <= e_dropped;
          end
          pend_q <= root2_v;
          here_q <= root2_v;
          cur_q  <= '0;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_vtx_q  <= pend_q;
          out_last_q <= 1'b1;
          out_drop_q <= e_dropped;
        end
      end
      default: ;
    endcase
  end

  assign leader_o.valid         = out_vld_q;
  assign leader_o.leader_vertex = out_vtx_q;
  assign leader_o.leader_last   = out_last_q;
  assign leader_o.edges_dropped = out_drop_q;

endmodule

// ===== hdl/scl_edge_store.sv =====
`timescale 1ns / 1ps
module scl_edge_store import scl_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_VERTICES,
  parameter int unsigned MAX_EDGES    = DEF_EDGES,
  localparam int unsigned AW  = $clog2(MAX_VERTICES),
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1),
  localparam int unsigned EAW = $clog2(MAX_EDGES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  edge_ctl_t        ctl_i,
  input  logic [VTX_W-1:0] src_i,
  input  logic [VTX_W-1:0] dst_i,
  input  logic [VTX_W-1:0] n_i,
  input  logic [EAW-1:0]   rd_addr_i,
  output logic [AW-1:0]    rd_src_o,
  output logic [AW-1:0]    rd_dst_o,
  output logic [EW-1:0]    total_o,
  output logic             dropped_o
);

  logic [AW-1:0] src_mem [MAX_EDGES];
  logic [AW-1:0] dst_mem [MAX_EDGES];
  logic [EW-1:0] total_q;
  logic          dropped_q;
  logic          ok;
  logic [VTX_W-1:0] src_m1, dst_m1;

  assign ok = (src_i != '0) && (src_i <= n_i) && (dst_i != '0) && (dst_i <= n_i)
              && (total_q < EW'(MAX_EDGES));
  assign src_m1 = src_i - 7'd1;
  assign dst_m1 = dst_i - 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      dropped_q <= 1'b0;
    end else if (ctl_i.clear) begin
      total_q   <= '0;
      dropped_q <= 1'b0;
    end else if (ctl_i.load) begin
      if (ok) total_q <= total_q + EW'(1);
      else    dropped_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && ok) begin
      src_mem[total_q[EAW-1:0]] <= src_m1[AW-1:0];
      dst_mem[total_q[EAW-1:0]] <= dst_m1[AW-1:0];
    end
    rd_src_o <= src_mem[rd_addr_i];
    rd_dst_o <= dst_mem[rd_addr_i];
  end

  assign total_o   = total_q;
  assign dropped_o = dropped_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import scl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned RANDOM_EDGES = 392;

  typedef struct {
    logic [VTX_W-1:0] vertex;
    logic             last;
    logic             dropped;
  } leader_t;

  class leader_scoreboard;
    logic [VTX_W-1:0] src_mem [DEF_EDGES];
    logic [VTX_W-1:0] dst_mem [DEF_EDGES];
    int               edge_cnt;
    bit               seen [DEF_VERTICES+1];
    logic [VTX_W-1:0] finish_list [DEF_VERTICES];
    int               finish_cnt;
    logic [VTX_W-1:0] stk_vtx [DEF_VERTICES];
    int               stk_cur [DEF_VERTICES];
    bit               drop_flag;
    int               vcount;
    leader_t          expected_leaders [$];
    int               errors;
    int               leaders_seen;
    int               graphs_seen;

    function new();
      vcount = int'(VC_RESET);
      edge_cnt = 0;
      drop_flag = 0;
      errors = 0;
      leaders_seen = 0;
      graphs_seen = 0;
    endfunction

    function void set_count(logic [VTX_W-1:0] v);
      vcount = int'(v);
    endfunction

    function int active_vertices();
      if (vcount == 0) return 1;
      if (vcount > DEF_VERTICES) return DEF_VERTICES;
      return vcount;
    endfunction

    // Iterative depth-first walk; each stack entry keeps its own edge cursor.
    function void walk(int root, bit rev, bit rec, int n);
      int depth, top, here, cur, from, to;
      bit pushed;
      seen[root] = 1;
      stk_vtx[0] = VTX_W'(root);
      stk_cur[0] = 0;
      depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        here = int'(stk_vtx[top]);
        cur = stk_cur[top];
        pushed = 0;
        while (cur < edge_cnt && !pushed) begin
          from = rev ? int'(dst_mem[cur]) : int'(src_mem[cur]);
          to = rev ? int'(src_mem[cur]) : int'(dst_mem[cur]);
          cur++;
          if (from == here && to >= 1 && to <= n && !seen[to] && depth < DEF_VERTICES) begin
            seen[to] = 1;
            stk_cur[top] = cur;
            stk_vtx[depth] = VTX_W'(to);
            stk_cur[depth] = 0;
            depth++;
            pushed = 1;
          end
        end
        if (!pushed) begin
          stk_cur[top] = cur;
          depth--;
          if (rec && finish_cnt < DEF_VERTICES) begin
            finish_list[finish_cnt] = VTX_W'(here);
            finish_cnt++;
          end
        end
      end
    endfunction

    function void note_edge(logic [VTX_W-1:0] s, logic [VTX_W-1:0] d, logic last);
      int n, start;
      leader_t l;
      n = active_vertices();
      if (s < 1 || s > n || d < 1 || d > n || edge_cnt >= DEF_EDGES) begin
        drop_flag = 1;
      end else begin
        src_mem[edge_cnt] = s;
        dst_mem[edge_cnt] = d;
        edge_cnt++;
      end
      if (!last) return;
      graphs_seen++;
      foreach (seen[i]) seen[i] = 0;
      finish_cnt = 0;
      for (int i = n; i >= 1; i--)
        if (!seen[i]) walk(i, 0, 1, n);
      foreach (seen[i]) seen[i] = 0;
      start = expected_leaders.size();
      for (int i = finish_cnt; i >= 1; i--) begin
        if (!seen[finish_list[i-1]]) begin
          walk(int'(finish_list[i-1]), 1, 0, n);
          l.vertex = finish_list[i-1];
          l.last = 0;
          l.dropped = drop_flag;
          expected_leaders = {expected_leaders, l};
        end
      end
      if (expected_leaders.size() > start)
        expected_leaders[expected_leaders.size()-1].last = 1;
      edge_cnt = 0;
      drop_flag = 0;
    endfunction

    task report(string what, int exp_v, int got_v);
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
      errors++;
    endtask

    task check_leader(leader_t got);
      leader_t exp_l;
      leaders_seen++;
      if (expected_leaders.size() == 0) begin
        report("unexpected leader word", -1, int'(got.vertex));
        return;
      end
      exp_l = expected_leaders.pop_front();
      if (got.vertex !== exp_l.vertex)
        report("leader_vertex", int'(exp_l.vertex), int'(got.vertex));
      if (got.last !== exp_l.last) report("leader_last", int'(exp_l.last), int'(got.last));
      if (got.dropped !== exp_l.dropped)
        report("edges_dropped", int'(exp_l.dropped), int'(got.dropped));
    endtask

    function int pending();
      return expected_leaders.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  scl_edge_if   edge_bus();
  scl_leader_if leader_bus();
  scl_cfg_if    cfg_bus();

  strongly_connected_leaders dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .edge_i   (edge_bus),
    .leader_o (leader_bus),
    .cfg_i    (cfg_bus)
  );

  leader_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off;
  int  cycles;
  int  edges_sent;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    cycles = 0;
    edges_sent = 0;
    rst_ni = 1'b0;
    edge_bus.valid = 1'b0;
    edge_bus.edge_src = '0;
    edge_bus.edge_dst = '0;
    edge_bus.edge_last = 1'b0;
    leader_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("strongly_connected_leaders test failed");
      $finish;
    end
  end

  // Receiver: a long hold-off takes precedence over random stalls.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off = hold_off - 1;
      leader_bus.ready <= 1'b0;
    end else begin
      leader_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    leader_t got;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.set_count(cfg_bus.data);
      if (edge_bus.valid && edge_bus.ready)
        sb.note_edge(edge_bus.edge_src, edge_bus.edge_dst, edge_bus.edge_last);
      if (leader_bus.valid && leader_bus.ready) begin
        got.vertex = leader_bus.leader_vertex;
        got.last = leader_bus.leader_last;
        got.dropped = leader_bus.edges_dropped;
        sb.check_leader(got);
      end
    end
  end

  task send_edge(int s, int d, bit last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      edge_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    edge_bus.valid <= 1'b1;
    edge_bus.edge_src <= s[VTX_W-1:0];
    edge_bus.edge_dst <= d[VTX_W-1:0];
    edge_bus.edge_last <= last;
    @(posedge clk_i);
    while (!edge_bus.ready) @(posedge clk_i);
    edges_sent++;
  endtask

  // Drop valid, wait for every leader, then let the walk settle.
  task drain();
    edge_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task write_count(int v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= v[VTX_W-1:0];
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task random_graph(int n_edges, int vc);
    int n, s, d;
    n = (vc == 0) ? 1 : (vc > DEF_VERTICES) ? DEF_VERTICES : vc;
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        s = $urandom_range(1, n);
        d = $urandom_range(1, n);
      end else begin
        s = $urandom_range(0, 127);
        d = $urandom_range(0, 127);
      end
      send_edge(s, d, i == n_edges - 1);
    end
  endtask

  initial begin
    int vc, ne, g, rnd_edges;
    #0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset count, empty graph once the only edge is dropped.
    send_edge(64, 1, 1);
    send_edge(0, 0, 1);
    drain();
    write_count(1);
    send_edge(1, 1, 1);
    drain();
    write_count(5);
    send_edge(1, 2, 0);
    send_edge(2, 3, 0);
    send_edge(3, 1, 0);
    send_edge(127, 3, 0);
    send_edge(4, 5, 0);
    send_edge(5, 0, 0);
    send_edge(3, 4, 1);
    drain();
    // Shrink the vertex count after loading edges that touch high vertices.
    write_count(8);
    send_edge(8, 7, 0);
    send_edge(7, 8, 0);
    send_edge(2, 1, 0);
    drain();
    write_count(3);
    send_edge(1, 2, 1);
    drain();
    write_count(0);
    send_edge(2, 1, 0);
    send_edge(1, 1, 1);
    drain();
    write_count(127);
    send_edge(64, 63, 0);
    send_edge(63, 64, 1);
    drain();

    // Random graphs across idle phases; graph 6 runs under a long hold-off.
    g = 0;
    rnd_edges = 0;
    while (rnd_edges < RANDOM_EDGES) begin
      case (g % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      case ($urandom_range(0, 9))
        0: vc = 64;
        1: vc = 1;
        2: vc = $urandom_range(65, 127);
        3: vc = 0;
        default: vc = $urandom_range(2, 12);
      endcase
      write_count(vc);
      ne = $urandom_range(1, 12);
      if (g == 6) begin
        hold_off = 3000;
        random_graph(ne, vc);
        random_graph(6, vc);
        rnd_edges += 6;
      end else begin
        random_graph(ne, vc);
      end
      rnd_edges += ne;
      drain();
      g++;
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    edge_bus.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d graphs from %0d edge words, %0d leader words checked",
             sb.graphs_seen, edges_sent, sb.leaders_seen);
    $display("vertex counts at both extremes, dropped edges, a held-off receiver and stalls");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("strongly_connected_leaders test passed");
    end else begin
      $display("strongly_connected_leaders test failed");
    end
    $finish;
  end

endmodule
